// ----- sv/crc8fc_pkg.sv -----
package crc8fc_pkg;

  // Reset value of the start register, and the reflected form of polynomial 0x31
  localparam logic [7:0] CRC_INIT_RESET = 8'hFF;
  localparam logic [7:0] CRC_POLY_REFL  = 8'h8C;

  // Byte count: the length byte plus one covers at most 256 bytes
  localparam int unsigned COUNT_W = 9;

  // Depth of the result queue
  localparam int unsigned RESQ_DEPTH = 2;

  typedef struct packed {
    logic       crc_ok;
    logic [7:0] computed_crc;
    logic [7:0] received_crc;
  } result_t;

  // One byte through the reflected CRC-8, one bit per step.
  // Gives the familiar lookup entries 0x00, 0x5e, 0xbc, 0xe2, ...
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY_REFL) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ----- sv/crc8fc_byte_if.sv -----
interface crc8fc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// ----- sv/crc8fc_result_if.sv -----
interface crc8fc_result_if;
  logic       valid;
  logic       ready;
  logic       crc_ok;
  logic [7:0] computed_crc;
  logic [7:0] received_crc;

  modport source (output valid, output crc_ok, output computed_crc, output received_crc,
                  input ready);
  modport sink (input valid, input crc_ok, input computed_crc, input received_crc,
                output ready);
endinterface

// ----- sv/crc8fc_result_q.sv -----
module crc8fc_result_q #(
  parameter int unsigned DEPTH = crc8fc_pkg::RESQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crc8fc_pkg::result_t push_data,
  output logic                full,
  output logic                pop_valid,
  input  logic                pop_ready,
  output crc8fc_pkg::result_t pop_data
);
  import crc8fc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = slots[rd_ptr];

  // Store a new result at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("result pushed into full queue");

  a_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("result queue count did not grow on push");
`endif

endmodule

// ----- sv/crc8_frame_checker_core.sv -----
// CRC-8 frame checker.
// byte_ch carries received frame bytes, one per transfer; frame_start marks the
// length byte L. The length byte, the type byte and L payload bytes run through
// a reflected CRC-8 (polynomial 0x31) seeded from the crc_init register; the next
// byte is taken as the received checksum. For that byte one transfer leaves on
// result_ch with the computed CRC, the received byte and a match flag. A byte
// with frame_start inside a frame drops the open frame; a byte outside a frame
// is dropped. Nothing else produces a result.
// Throughput: one byte per cycle while the result queue has room; the CRC update is
// one byte step between the frame state registers and the result queue.
// Output: each result is stored in the queue as its checksum byte is taken.
// Stall: results wait in a two-entry queue; byte_ch keeps taking bytes until the
// queue is full, then ready drops until result_ch takes a transfer.
// Reset (rst, synchronous): no frame open, queue empty, crc_init back to 0xFF.
// cfg_we writes cfg_wdata into crc_init; write it only while no frame is open.
module crc8_frame_checker_core #(
  parameter int unsigned RESQ_DEPTH = crc8fc_pkg::RESQ_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  crc8fc_byte_if.sink            byte_ch,
  crc8fc_result_if.source        result_ch,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata
);
  import crc8fc_pkg::*;

  logic [7:0]         crc_init;
  logic [7:0]         running_crc;
  logic [7:0]         running_crc_next;
  logic [COUNT_W-1:0] bytes_left;
  logic [COUNT_W-1:0] bytes_left_next;
  logic               in_frame;
  logic               in_frame_next;
  logic               accept;
  logic               push;
  logic               q_full;
  logic [7:0]         crc_seed;
  logic [7:0]         crc_upd;
  result_t            res_in;
  result_t            res_out;

  assign byte_ch.ready = !q_full;
  assign accept        = byte_ch.valid && byte_ch.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_init <= CRC_INIT_RESET;
    end else if (cfg_we) begin
      crc_init <= cfg_wdata;
    end
  end

  // One byte step of the CRC, seeded from crc_init on the length byte
  assign crc_seed = byte_ch.frame_start ? crc_init : running_crc;
  assign crc_upd  = crc8_byte(crc_seed, byte_ch.data_byte);

  // Checksum byte: in a frame, no start, nothing left to fold in
  assign push = accept && !byte_ch.frame_start && in_frame && (bytes_left == '0);

  assign res_in.crc_ok       = (running_crc == byte_ch.data_byte);
  assign res_in.computed_crc = running_crc;
  assign res_in.received_crc = byte_ch.data_byte;

  // Frame tracking
  always_comb begin
    running_crc_next = running_crc;
    bytes_left_next  = bytes_left;
    in_frame_next    = in_frame;
    if (accept) begin
      if (byte_ch.frame_start) begin
        running_crc_next = crc_upd;
        bytes_left_next  = COUNT_W'(byte_ch.data_byte) + 1'b1;
        in_frame_next    = 1'b1;
      end else if (in_frame) begin
        if (bytes_left != '0) begin
          running_crc_next = crc_upd;
          bytes_left_next  = bytes_left - 1'b1;
        end else begin
          in_frame_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_INIT_RESET;
      bytes_left  <= '0;
      in_frame    <= 1'b0;
    end else begin
      running_crc <= running_crc_next;
      bytes_left  <= bytes_left_next;
      in_frame    <= in_frame_next;
    end
  end

  // Hold results until the receiver takes them
  crc8fc_result_q #(
    .DEPTH (RESQ_DEPTH)
  ) u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res_in),
    .full      (q_full),
    .pop_valid (result_ch.valid),
    .pop_ready (result_ch.ready),
    .pop_data  (res_out)
  );

  assign result_ch.crc_ok       = res_out.crc_ok;
  assign result_ch.computed_crc = res_out.computed_crc;
  assign result_ch.received_crc = res_out.received_crc;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= COUNT_W'(256))
    else $error("byte count beyond 256");

  a_close_on_result: assert property (@(posedge clk) disable iff (rst)
    push |=> !in_frame)
    else $error("frame still open after its result");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> bytes_left == '0)
    else $error("byte count left over outside a frame");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import crc8fc_pkg::*;

  // Rows of the directed table: a byte transfer or a write of crc_init
  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] data;
    logic       start;
    bit         typed;
    result_t    res;
  } dir_row_t;

  localparam int N_DIR_ROWS = 26;
  localparam int N_PHASES   = 5;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  crc8fc_byte_if   byte_ch ();
  crc8fc_result_if result_ch ();

  crc8_frame_checker_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Frame tracker state, mirrors what the checker should hold
  logic [7:0] mdl_init;
  logic [7:0] mdl_crc;
  logic [8:0] mdl_left;
  bit         mdl_open;

  result_t crc_results_due[$];
  int burst_left;
  int n_items;
  int n_ignored;
  int n_results;
  int n_fail;
  int n_inits;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run one byte through the reflected CRC-8, bit by bit
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY_REFL : 8'h00);
    return r;
  endfunction

  // Advance the frame tracker by one byte; report the result it yields, if any
  task automatic predict_frame_byte(input logic [7:0] d, input logic s,
                                    output bit emits, output result_t res);
    emits = 1'b0;
    res = '0;
    if (s) begin
      mdl_crc  = crc_step(mdl_init, d);
      mdl_left = {1'b0, d} + 9'd1;
      mdl_open = 1'b1;
    end else if (mdl_open) begin
      if (mdl_left != 9'd0) begin
        mdl_crc  = crc_step(mdl_crc, d);
        mdl_left = mdl_left - 9'd1;
      end else begin
        emits            = 1'b1;
        res.crc_ok       = (mdl_crc == d);
        res.computed_crc = mdl_crc;
        res.received_crc = d;
        mdl_open         = 1'b0;
      end
    end
  endtask

  // Offer one byte, in bursts with random gaps; hold it until the transfer
  task automatic push_byte(input logic [7:0] d, input logic s,
                           input bit typed, input result_t typed_res);
    bit emits;
    result_t res;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= d;
    byte_ch.frame_start <= s;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    burst_left--;
    if (s || mdl_open) n_items++;
    else n_ignored++;
    predict_frame_byte(d, s, emits, res);
    if (emits) crc_results_due.push_back(typed ? typed_res : res);
  endtask

  // Let every pending result drain, then allow the pipeline to settle
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    while (crc_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_crc_init(input logic [7:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mdl_init = v;
    n_inits++;
  endtask

  // Send one frame of len payload bytes; with cut_at >= 0 stop after that many
  // bytes past the length byte and leave the frame open
  task automatic send_frame(input int len, input bit good, input int cut_at);
    logic [7:0] acc;
    logic [7:0] b;
    acc = crc_step(mdl_init, len[7:0]);
    push_byte(len[7:0], 1'b1, 1'b0, '0);
    for (int i = 0; i <= len; i++) begin
      if (i == cut_at) return;
      b = 8'($urandom_range(0, 255));
      acc = crc_step(acc, b);
      push_byte(b, 1'b0, 1'b0, '0);
    end
    if (cut_at == len + 1) return;
    b = good ? acc : 8'($urandom_range(0, 255));
    push_byte(b, 1'b0, 1'b0, '0);
  endtask

  // Receiver: switch between random stall patterns, hold off once for a long stretch
  initial begin
    int cyc;
    int mode;
    bit held;
    cyc = 0;
    mode = 0;
    held = 1'b0;
    result_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && n_results >= 20) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        cyc++;
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: begin
            result_ch.ready <= 1'b1;
          end
          1: begin
            result_ch.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            result_ch.ready <= (cyc % 4 == 0);
          end
          default: begin
            result_ch.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest expected one
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      n_results++;
      if (crc_results_due.size() == 0) begin
        $error("unexpected result: crc_ok=%0d computed_crc=%02h received_crc=%02h",
               result_ch.crc_ok, result_ch.computed_crc, result_ch.received_crc);
        n_fail++;
      end else begin
        want = crc_results_due.pop_front();
        if (result_ch.crc_ok !== want.crc_ok) begin
          $error("crc_ok: expected %0d, got %0d", want.crc_ok, result_ch.crc_ok);
          n_fail++;
        end
        if (result_ch.computed_crc !== want.computed_crc) begin
          $error("computed_crc: expected %02h, got %02h",
                 want.computed_crc, result_ch.computed_crc);
          n_fail++;
        end
        if (result_ch.received_crc !== want.received_crc) begin
          $error("received_crc: expected %02h, got %02h",
                 want.received_crc, result_ch.received_crc);
          n_fail++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t dir_rows [N_DIR_ROWS];
    logic [7:0] init_plan [N_PHASES];
    int phase_start;
    int pick;
    int len;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.frame_start = 1'b0;
    mdl_init = CRC_INIT_RESET;
    mdl_crc = 8'hFF;
    mdl_left = '0;
    mdl_open = 1'b0;
    burst_left = 0;
    n_items = 0;
    n_ignored = 0;
    n_results = 0;
    n_fail = 0;
    n_inits = 1;

    dir_rows = '{
      // byte while idle, then a zero-length frame from the reset init value
      '{ROW_BYTE, 8'h12, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b1, 1'b0, '0},
      '{ROW_BYTE, 8'hAA, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'h5C, 1'b0, 1'b0, '0},
      // init zero: all-zero frame gives CRC zero
      '{ROW_CFG,  8'h00, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b1, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, 8'h00}},
      '{ROW_BYTE, 8'h00, 1'b1, 1'b0, '0},
      '{ROW_BYTE, 8'h03, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'hE2, 1'b0, 1'b1, '{1'b1, 8'hE2, 8'hE2}},
      // checksum mismatch
      '{ROW_BYTE, 8'h00, 1'b1, 1'b0, '0},
      '{ROW_BYTE, 8'h02, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, '{1'b0, 8'hBC, 8'hFF}},
      // start inside a frame drops it
      '{ROW_BYTE, 8'h05, 1'b1, 1'b0, '0},
      '{ROW_BYTE, 8'h33, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'h44, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b1, 1'b0, '0},
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'h5E, 1'b0, 1'b1, '{1'b1, 8'h5E, 8'h5E}},
      // start where the checksum is due
      '{ROW_BYTE, 8'h00, 1'b1, 1'b0, '0},
      '{ROW_BYTE, 8'h7E, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'h01, 1'b1, 1'b0, '0},
      '{ROW_BYTE, 8'h55, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'h66, 1'b0, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, '0}
    };
    init_plan = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
    init_plan[1] = 8'($urandom_range(1, 254));
    init_plan[4] = 8'($urandom_range(0, 255));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_crc_init(dir_rows[i].data);
      else push_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random frames, one init setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      write_crc_init(init_plan[p]);
      phase_start = n_items;
      if (p == 2) send_frame(255, 1'b1, -1);
      while (n_items - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        len = $urandom_range(0, 99);
        if (len < 2) len = $urandom_range(128, 255);
        else if (len < 65) len = $urandom_range(0, 3);
        else len = $urandom_range(4, 24);
        if (pick < 8 && !mdl_open) begin
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end else if (pick < 22) begin
          send_frame(len, 1'($urandom_range(0, 1)), $urandom_range(0, len + 1));
        end else begin
          send_frame(len, 1'($urandom_range(0, 1)), -1);
        end
      end
      // Close the phase on a complete frame so no frame is open at the next write
      send_frame($urandom_range(0, 3), 1'b1, -1);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("summary: %0d frame bytes and %0d idle bytes sent, %0d results checked",
             n_items, n_ignored, n_results);
    $display("summary: %0d crc_init settings, %0d mismatches", n_inits, n_fail);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #2000000;
    $display("timeout with %0d results still due", crc_results_due.size());
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/crc8fc_pkg.sv
sv/crc8fc_byte_if.sv
sv/crc8fc_result_if.sv
sv/crc8fc_result_q.sv
sv/crc8_frame_checker_core.sv
dv/tb_top.sv
